// ===== src/pose_change_detector_top_assert.svh =====
// ----------------------------------------------------------------------------
// Pose change detector assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef POSE_CHANGE_DETECTOR_TOP_ASSERT_SVH
`define POSE_CHANGE_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCD_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pose change detector check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pose change detector check failed");

`endif

// ===== src/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Pose change detector package
// Fixed widths, constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int unsigned ANG_W     = 27;
  localparam int unsigned Z_W       = 30;
  localparam int unsigned XY_W      = 34;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int DEG180_Q16 = 11796480;
  localparam int DEG360_Q16 = 23592960;
  localparam int DEG90_Q20  = 94371840;
  localparam int ONE_Q16    = 65536;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT   = 2'd1;

  localparam logic [31:0] TRANS_RESET = 32'd6554;
  localparam logic [25:0] ROT_RESET   = 26'd327680;

  localparam logic ACT_LOAD = 1'b0;

  // atan(2^-i) in degrees, scaled by 2^20.
  function automatic logic [25:0] atan_q20(input logic [4:0] i);
    logic [25:0] r;
    unique case (i)
      5'd0:  r = 26'd47185920;
      5'd1:  r = 26'd27855475;
      5'd2:  r = 26'd14718068;
      5'd3:  r = 26'd7471121;
      5'd4:  r = 26'd3750058;
      5'd5:  r = 26'd1876857;
      5'd6:  r = 26'd938658;
      5'd7:  r = 26'd469357;
      5'd8:  r = 26'd234682;
      5'd9:  r = 26'd117342;
      5'd10: r = 26'd58671;
      5'd11: r = 26'd29335;
      5'd12: r = 26'd14668;
      5'd13: r = 26'd7334;
      5'd14: r = 26'd3667;
      5'd15: r = 26'd1833;
      5'd16: r = 26'd917;
      5'd17: r = 26'd458;
      5'd18: r = 26'd229;
      5'd19: r = 26'd115;
      5'd20: r = 26'd57;
      5'd21: r = 26'd29;
      5'd22: r = 26'd14;
      5'd23: r = 26'd7;
      5'd24: r = 26'd4;
      5'd25: r = 26'd2;
      5'd26: r = 26'd1;
      default: r = 26'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/pcd_if.sv =====
// ----------------------------------------------------------------------------
// Pose change detector channels
// Valid/ready channels for pose items, result items and register writes.
// ----------------------------------------------------------------------------
interface pcd_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [17:0] rot_00;
  logic signed [17:0] rot_10;
  logic signed [17:0] rot_20;
  logic signed [17:0] rot_21;
  logic signed [17:0] rot_22;
  modport source (output valid, action, pos_x, pos_y, pos_z,
                  rot_00, rot_10, rot_20, rot_21, rot_22, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z,
                  rot_00, rot_10, rot_20, rot_21, rot_22, output ready);
endinterface

interface pcd_out_if;
  logic        valid;
  logic        ready;
  logic        changed;
  logic [31:0] move_distance;
  logic [25:0] turn_sum;
  modport source (output valid, changed, move_distance, turn_sum, input ready);
  modport sink   (input valid, changed, move_distance, turn_sum, output ready);
endinterface

interface pcd_cfg_if import pcd_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pcd_cordic.sv =====
// ----------------------------------------------------------------------------
// Pose change detector CORDIC
// Iterative vectoring CORDIC, one micro-rotation per cycle, angle in degrees.
// ----------------------------------------------------------------------------
module pcd_cordic import pcd_pkg::*; #(
  parameter int unsigned ITERATIONS = 18
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [17:0]      y_i,
  input  logic signed [17:0]      x_i,
  output logic                    busy_o,
  output logic signed [ANG_W-1:0] angle_o
);

  localparam int unsigned N     = (ITERATIONS > 32) ? 32 : ITERATIONS;
  localparam int unsigned CNT_W = $clog2(N);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(N - 1);
  localparam logic signed [Z_W-1:0] LIM = Z_W'(DEG180_Q16);

  logic                   busy_q;
  logic [CNT_W-1:0]       cnt_q;
  logic signed [XY_W-1:0] x_q, y_q, xs, ys, x0, y0;
  logic signed [Z_W-1:0]  z_q, step, zr;

  assign x0   = {{(XY_W-30){x_i[17]}}, x_i, 12'b0};
  assign y0   = {{(XY_W-30){y_i[17]}}, y_i, 12'b0};
  assign xs   = x_q >>> cnt_q;
  assign ys   = y_q >>> cnt_q;
  assign step = $signed({{(Z_W-26){1'b0}}, atan_q20(5'(cnt_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !(x_i == 18'sd0 && y_i == 18'sd0);
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i == 18'sd0 && y_i == 18'sd0) begin
        x_q <= x0;
        y_q <= y0;
        z_q <= '0;
      end else if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q <= y0;
          y_q <= -x0;
          z_q <= Z_W'(DEG90_Q20);
        end else begin
          x_q <= -y0;
          y_q <= x0;
          z_q <= -Z_W'(DEG90_Q20);
        end
      end else begin
        x_q <= x0;
        y_q <= y0;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + step;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - step;
      end
    end
  end

  // Round the Q.20 sum to Q.16 and clamp to half a turn.
  always_comb begin
    zr = (z_q + Z_W'(8)) >>> 4;
    if (zr > LIM) begin
      zr = LIM;
    end else if (zr < -LIM) begin
      zr = -LIM;
    end
  end

  assign busy_o  = busy_q;
  assign angle_o = ANG_W'(zr);

endmodule

// ===== src/pcd_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pose change detector square root
// Digit-by-digit integer square root of 64 bits, one result bit per cycle.
// ----------------------------------------------------------------------------
module pcd_isqrt import pcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic [63:0] v_q, res_q, one_q, trial;

  assign trial = res_q + one_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && one_q == 64'd1) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= rad_i;
      res_q <= '0;
      one_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + one_q;
      end else begin
        res_q <= res_q >> 1;
      end
      one_q <= one_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[31:0];

endmodule

// ===== src/pose_change_detector_top.sv =====
// ----------------------------------------------------------------------------
// Pose change detector
// Keyframe test of a pose against a stored reference pose.
// ----------------------------------------------------------------------------
// A load item computes the three angles and stores the pose as the reference.
// A compare item also sums the squared translation differences and takes their
// root, which is skipped when the sum saturates the distance. A new item is
// taken only in idle. The yaw CORDIC overlaps the cosine root, and a result
// still waiting at the output adds its stall. Reset clears the reference pose.
module pose_change_detector_top import pcd_pkg::*; #(
  parameter int unsigned ANGLE_ITERATIONS = 18
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pcd_in_if.sink   item_i,
  pcd_out_if.source result_o,
  pcd_cfg_if.sink  cfg_i
);

  // Sequencer codes.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_YAW   = 4'd2;
  localparam logic [3:0] ST_PITCH = 4'd3;
  localparam logic [3:0] ST_ROLL  = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_ACC   = 4'd6;
  localparam logic [3:0] ST_DIST  = 4'd7;
  localparam logic [3:0] ST_DWAIT = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0] state_q;
  logic [1:0] k_q;

  // Configuration registers. Writes are always taken.
  logic [31:0] trans_thr_q;
  logic [25:0] rot_thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_thr_q <= TRANS_RESET;
      rot_thr_q   <= ROT_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_TRANS) begin
        trans_thr_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_ROT) begin
        rot_thr_q <= cfg_i.data[25:0];
      end
    end
  end

  // Latched item fields.
  logic                    action_q;
  logic signed [31:0]      pos_q [3];
  logic signed [17:0]      r00_q, r10_q, r21_q, r22_q, s_q;
  logic signed [ANG_W-1:0] ang_q [3];

  // Reference pose, reset to zero.
  logic signed [31:0]      ref_pos_q [3];
  logic signed [ANG_W-1:0] ref_ang_q [3];

  // Pitch uses asin(-rot_20); the negated entry is clamped to one first.
  logic signed [18:0] neg_r20;
  logic signed [17:0] s_clamp;

  always_comb begin
    neg_r20 = -{item_i.rot_20[17], item_i.rot_20};
    if (neg_r20 > 19'sd65536) begin
      s_clamp = 18'sd65536;
    end else if (neg_r20 < -19'sd65536) begin
      s_clamp = -18'sd65536;
    end else begin
      s_clamp = neg_r20[17:0];
    end
  end

  // Shared arithmetic units.
  logic                    c_start, c_busy;
  logic signed [17:0]      c_y, c_x;
  logic signed [ANG_W-1:0] c_angle;
  logic                    q_start, q_busy;
  logic [63:0]             q_rad;
  logic [31:0]             q_root;
  logic signed [35:0]      s_sq;
  logic [65:0]             sum_q;

  assign s_sq = s_q * s_q;

  always_comb begin
    c_start = 1'b0;
    c_y     = r10_q;
    c_x     = r00_q;
    q_start = 1'b0;
    q_rad   = sum_q[63:0];
    unique case (state_q)
      ST_PREP: begin
        c_start = 1'b1;
        q_start = 1'b1;
        q_rad   = (64'd1 << 32) - {28'b0, s_sq};
      end
      ST_YAW: begin
        c_start = !c_busy && !q_busy;
        c_y     = s_q;
        c_x     = q_root[17:0];
      end
      ST_PITCH: begin
        c_start = !c_busy;
        c_y     = r21_q;
        c_x     = r22_q;
      end
      ST_DIST: begin
        q_start = (sum_q[65:64] == 2'b00);
      end
      default: begin
      end
    endcase
  end

  pcd_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (c_start),
    .y_i     (c_y),
    .x_i     (c_x),
    .busy_o  (c_busy),
    .angle_o (c_angle)
  );

  pcd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (q_start),
    .rad_i   (q_rad),
    .busy_o  (q_busy),
    .root_o  (q_root)
  );

  // Per-axis compare terms: squared translation difference and wrapped angle.
  logic signed [32:0]      pd;
  logic [31:0]             pa;
  logic [63:0]             prod_q;
  logic signed [ANG_W:0]   ad;
  logic [ANG_W-1:0]        am, aw;
  logic [25:0]             turn_q;

  always_comb begin
    pd = {ref_pos_q[k_q][31], ref_pos_q[k_q]} - {pos_q[k_q][31], pos_q[k_q]};
    pa = pd[32] ? 32'(-pd) : pd[31:0];
    ad = {ref_ang_q[k_q][ANG_W-1], ref_ang_q[k_q]} - {ang_q[k_q][ANG_W-1], ang_q[k_q]};
    am = ad[ANG_W] ? ANG_W'(-ad) : ad[ANG_W-1:0];
    aw = (ANG_W'(DEG360_Q16) - am < am) ? ANG_W'(DEG360_Q16) - am : am;
  end

  // Result decision.
  logic        over;
  logic [31:0] dist_val;
  logic        changed;

  assign over     = (sum_q[65:64] != 2'b00);
  assign dist_val = over ? 32'hFFFF_FFFF : q_root;
  assign changed  = over || (dist_val > trans_thr_q) || (turn_q > rot_thr_q);

  logic out_valid_q;
  logic out_free;

  assign out_free     = !out_valid_q || result_o.ready;
  assign item_i.ready = (state_q == ST_IDLE);
  assign result_o.valid = out_valid_q;

  // Sequencer and reference state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ref_pos_q[i] <= '0;
        ref_ang_q[i] <= '0;
      end
    end else begin
      // The output state loads the next result itself, so it never clears it.
      if (result_o.ready && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (item_i.valid) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_q <= ST_YAW;
        end
        ST_YAW: begin
          if (!c_busy && !q_busy) begin
            state_q <= ST_PITCH;
          end
        end
        ST_PITCH: begin
          if (!c_busy) begin
            state_q <= ST_ROLL;
          end
        end
        ST_ROLL: begin
          if (!c_busy) begin
            k_q <= 2'd0;
            if (action_q == ACT_LOAD) begin
              // A load item takes the new pose as the reference.
              for (int i = 0; i < 3; i++) begin
                ref_pos_q[i] <= pos_q[i];
              end
              ref_ang_q[0] <= ang_q[0];
              ref_ang_q[1] <= ang_q[1];
              ref_ang_q[2] <= c_angle;
              state_q      <= ST_IDLE;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (k_q == 2'd2) begin
            state_q <= ST_DIST;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_MUL;
          end
        end
        ST_DIST: begin
          state_q <= over ? ST_OUT : ST_DWAIT;
        end
        ST_DWAIT: begin
          if (!q_busy) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      action_q <= item_i.action;
      pos_q[0] <= item_i.pos_x;
      pos_q[1] <= item_i.pos_y;
      pos_q[2] <= item_i.pos_z;
      r00_q    <= item_i.rot_00;
      r10_q    <= item_i.rot_10;
      r21_q    <= item_i.rot_21;
      r22_q    <= item_i.rot_22;
      s_q      <= s_clamp;
    end
    if (state_q == ST_YAW && !c_busy && !q_busy) begin
      ang_q[0] <= c_angle;
    end
    if (state_q == ST_PITCH && !c_busy) begin
      ang_q[1] <= c_angle;
    end
    if (state_q == ST_ROLL && !c_busy) begin
      ang_q[2] <= c_angle;
      sum_q    <= '0;
      turn_q   <= '0;
    end
    if (state_q == ST_MUL) begin
      prod_q <= pa * pa;
      turn_q <= turn_q + 26'(aw);
    end
    if (state_q == ST_ACC) begin
      sum_q <= sum_q + {2'b00, prod_q};
    end
    if (state_q == ST_OUT && out_free) begin
      result_o.changed       <= changed;
      result_o.move_distance <= dist_val;
      result_o.turn_sum      <= turn_q;
    end
  end

endmodule

// ===== src/pcd_checker.sv =====
// ----------------------------------------------------------------------------
// Pose change detector port checker
// Watches the top level's item and result channels and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "pose_change_detector_top_assert.svh"

module pcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        changed_i,
  input logic [31:0] dist_i,
  input logic [25:0] turn_i
);

  // A waiting result holds its value until it is taken.
  `PCD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(dist_i) && $stable(turn_i) && $stable(changed_i))

  // The block works on one item at a time.
  `PCD_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // Three wrapped differences never exceed 540 degrees.
  `PCD_ASSERT_NOW(a_turn_max, clk_i, rst_ni, out_valid_i, turn_i <= 26'd35389440)

endmodule

bind pose_change_detector_top pcd_checker u_pcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .changed_i   (result_o.changed),
  .dist_i      (result_o.move_distance),
  .turn_i      (result_o.turn_sum)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Pose change detector testbench
// Drives load and compare poses, register writes and random idling, predicts
// each result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module testbench import pcd_pkg::*;;

  localparam int unsigned ITERS = 18;

  // Register index past the end of the list; writes to it are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic               action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [17:0] rot_00;
    logic signed [17:0] rot_10;
    logic signed [17:0] rot_20;
    logic signed [17:0] rot_21;
    logic signed [17:0] rot_22;
  } pose_t;

  typedef struct packed {
    logic        changed;
    logic [31:0] move_distance;
    logic [25:0] turn_sum;
  } verdict_t;

  // One row of the directed table; has_verdict marks a hand-typed result.
  typedef struct {
    pose_t    pose;
    logic     has_verdict;
    verdict_t verdict;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pcd_in_if  item_if ();
  pcd_out_if result_if ();
  pcd_cfg_if cfg_if ();

  pose_change_detector_top #(.ANGLE_ITERATIONS(ITERS)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if.sink),
    .result_o(result_if.source),
    .cfg_i   (cfg_if.sink)
  );

  // The clock runs at a period of 20 time units.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: thresholds and the stored reference pose.
  logic [31:0]        trans_limit;
  logic [25:0]        rot_limit;
  logic signed [31:0] ref_pos [3];
  logic signed [26:0] ref_ang [3];

  verdict_t pending_verdicts [$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  // Floor of the square root of a 64-bit value, digit by digit.
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint atan_table(input int i);
    longint tbl [27] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                         938658, 469357, 234682, 117342, 58671, 29335, 14668,
                         7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
                         4, 2, 1};
    return (i < 27) ? tbl[i] : 0;
  endfunction

  // Vectoring CORDIC atan2 giving signed Q10.16 degrees.
  function automatic logic signed [26:0] angle_of(input longint y, input longint x);
    longint z, t, xs, ys;
    if (x == 0 && y == 0) return '0;
    x = x * 4096;
    y = y * 4096;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = DEG90_Q20;
      end else begin
        t = x; x = -y; y = t; z = -DEG90_Q20;
      end
    end
    for (int i = 0; i < ITERS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_table(i));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_table(i));
      end
    end
    z = (z + 8) >>> 4;
    if (z > DEG180_Q16) z = DEG180_Q16;
    if (z < -DEG180_Q16) z = -DEG180_Q16;
    return z[26:0];
  endfunction

  // Pitch from asin, built as atan2 of sine against the recovered cosine.
  function automatic logic signed [26:0] pitch_of(input longint s);
    logic [63:0] c;
    if (s > ONE_Q16) s = ONE_Q16;
    if (s < -ONE_Q16) s = -ONE_Q16;
    c = root_floor((64'd1 << 32) - 64'(s * s));
    return angle_of(s, longint'(c));
  endfunction

  function automatic longint wrapped_gap(input longint a, input longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    if (DEG360_Q16 - d < d) d = DEG360_Q16 - d;
    return d;
  endfunction

  // Applies one accepted pose to the predictor; queues a verdict for compares.
  task automatic predict_pose(input pose_t p);
    logic signed [31:0] pos [3];
    logic signed [26:0] ang [3];
    logic [63:0]        sq_sum;
    logic [64:0]        wide;
    logic               over;
    longint             d;
    longint             turn;
    verdict_t           v;
    pos[0] = p.pos_x;
    pos[1] = p.pos_y;
    pos[2] = p.pos_z;
    ang[0] = angle_of(p.rot_10, p.rot_00);
    ang[1] = pitch_of(-longint'(p.rot_20));
    ang[2] = angle_of(p.rot_21, p.rot_22);
    if (p.action == ACT_LOAD) begin
      ref_pos = pos;
      ref_ang = ang;
      return;
    end
    sq_sum = 0;
    over   = 1'b0;
    turn   = 0;
    for (int i = 0; i < 3; i++) begin
      d = longint'(ref_pos[i]) - longint'(pos[i]);
      if (d < 0) d = -d;
      wide = {1'b0, sq_sum} + 65'(64'(d) * 64'(d));
      if (wide[64]) over = 1'b1;
      sq_sum = wide[63:0];
      turn = turn + wrapped_gap(ref_ang[i], ang[i]);
    end
    v.move_distance = over ? 32'hFFFF_FFFF : 32'(root_floor(sq_sum));
    v.turn_sum      = 26'(turn);
    v.changed       = over || (v.move_distance > trans_limit) || (v.turn_sum > rot_limit);
    pending_verdicts.push_back(v);
  endtask

  // Quiet defaults for every channel from time zero.
  initial begin
    item_if.valid  = 1'b0;
    item_if.action = 1'b0;
    item_if.pos_x  = '0;
    item_if.pos_y  = '0;
    item_if.pos_z  = '0;
    item_if.rot_00 = '0;
    item_if.rot_10 = '0;
    item_if.rot_20 = '0;
    item_if.rot_21 = '0;
    item_if.rot_22 = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_TRANS;
    cfg_if.data  = '0;
  end

  // Result checker: samples at the rising edge, compares with the oldest
  // expectation and keeps running after a mismatch.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result item: changed %0b distance %0h turn %0h",
               result_if.changed, result_if.move_distance, result_if.turn_sum);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (result_if.changed !== want.changed) begin
          $error("changed: expected %0b, got %0b", want.changed, result_if.changed);
          errors++;
        end
        if (result_if.move_distance !== want.move_distance) begin
          $error("move_distance: expected %0h, got %0h", want.move_distance,
                 result_if.move_distance);
          errors++;
        end
        if (result_if.turn_sum !== want.turn_sum) begin
          $error("turn_sum: expected %0h, got %0h", want.turn_sum, result_if.turn_sum);
          errors++;
        end
      end
    end
  end

  // The receiver stalls at random, changing ready only at the falling edge.
  always @(negedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Presents one pose and holds it until it is accepted; the prediction is made
  // at that same edge. The idle gap, if any, comes before the item, and valid
  // is dropped after acceptance while the block is busy anyway.
  task automatic send_pose(input pose_t p);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    item_if.valid  <= 1'b1;
    item_if.action <= p.action;
    item_if.pos_x  <= p.pos_x;
    item_if.pos_y  <= p.pos_y;
    item_if.pos_z  <= p.pos_z;
    item_if.rot_00 <= p.rot_00;
    item_if.rot_10 <= p.rot_10;
    item_if.rot_20 <= p.rot_20;
    item_if.rot_21 <= p.rot_21;
    item_if.rot_22 <= p.rot_22;
    do @(posedge clk_i); while (!item_if.ready);
    predict_pose(p);
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every expected result is in, then lets a load item that may
  // still be in flight finish before anything else changes.
  task automatic drain();
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (3 * ITERS + 100) @(negedge clk_i);
  endtask

  // Writes one configuration register index; only called while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_TRANS) trans_limit = val;
    else if (idx == CFG_ROT) rot_limit = val[25:0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [17:0] unit_entry();
    case ($urandom_range(5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'($urandom);
      default: return 18'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(3))
      0: return 32'($urandom);
      default: return 32'($signed($urandom_range(2097152)) - 1048576);
    endcase
  endfunction

  function automatic pose_t rand_pose(input logic act);
    pose_t p;
    p.action = act;
    p.pos_x  = rand_pos();
    p.pos_y  = rand_pos();
    p.pos_z  = rand_pos();
    p.rot_00 = unit_entry();
    p.rot_10 = unit_entry();
    p.rot_20 = unit_entry();
    p.rot_21 = unit_entry();
    p.rot_22 = unit_entry();
    return p;
  endfunction

  function automatic pose_t make_pose(input logic act, input int px, input int py,
                                      input int pz, input int r00, input int r10,
                                      input int r20, input int r21, input int r22);
    pose_t p;
    p = '{act, px, py, pz, 18'(r00), 18'(r10), 18'(r20), 18'(r21), 18'(r22)};
    return p;
  endfunction

  function automatic row_t row(input pose_t p, input logic hv, input verdict_t v);
    row_t r;
    r.pose = p;
    r.has_verdict = hv;
    r.verdict = v;
    return r;
  endfunction

  row_t directed [$];

  // Main sequence: reset, directed table, then random phases with register
  // changes in between.
  initial begin
    localparam logic ACT_CMP = ~ACT_LOAD;
    verdict_t nv;
    logic     want_load;
    logic [31:0] trans_set [4];
    logic [25:0] rot_set [4];
    trans_limit = TRANS_RESET;
    rot_limit   = ROT_RESET;
    for (int i = 0; i < 3; i++) begin
      ref_pos[i] = '0;
      ref_ang[i] = '0;
    end
    nv = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Identity pose against the reset reference; the CORDIC leaves a small
    // residue in each angle.
    directed.push_back(row(make_pose(ACT_CMP, 0, 0, 0, 65536, 0, 0, 0, 65536),
                           1'b0, nv));
    // All-zero rotation entries: yaw and roll fall back to zero.
    directed.push_back(row(make_pose(ACT_CMP, 0, 0, 0, 0, 0, 0, 0, 0),
                           1'b0, nv));
    // One metre along x is past the default threshold.
    directed.push_back(row(make_pose(ACT_CMP, 65536, 0, 0, 65536, 0, 0, 0, 65536),
                           1'b0, nv));
    // Largest translation gap saturates the distance.
    directed.push_back(row(make_pose(ACT_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 65536, 0, 0, 0, 65536), 1'b0, nv));
    directed.push_back(row(make_pose(ACT_CMP, 32'h80000000, 32'h80000000,
                                     32'h80000000, 65536, 0, 0, 0, 65536),
                           1'b1, '{1'b1, 32'hFFFFFFFF, 26'd0}));
    // Quarter-turn pre-rotation in both directions and negative x axis.
    directed.push_back(row(make_pose(ACT_LOAD, 0, 0, 0, -65536, 0, 0, 0, -65536),
                           1'b0, nv));
    directed.push_back(row(make_pose(ACT_CMP, 0, 0, 0, -65536, -1, 0, -1, -65536),
                           1'b0, nv));
    directed.push_back(row(make_pose(ACT_CMP, 0, 0, 0, 0, 65536, 65536, 65536, 0),
                           1'b0, nv));
    // Pitch entries beyond one are clamped before the asin.
    directed.push_back(row(make_pose(ACT_CMP, 1, -1, 1, 65536, 0, 131071, 0, 65536),
                           1'b0, nv));
    directed.push_back(row(make_pose(ACT_CMP, 0, 0, 0, 65536, 0, -131072, 0, 65536),
                           1'b0, nv));
    // Entries outside the unit range are used as given.
    directed.push_back(row(make_pose(ACT_LOAD, -5, 7, 9, 131071, -131072, -65536,
                                     -131072, 131071), 1'b0, nv));
    directed.push_back(row(make_pose(ACT_CMP, 32'h7FFFFFFF, 0, 32'h80000000,
                                     -131072, 131071, 65536, 131071, -131072),
                           1'b0, nv));
    directed.push_back(row(make_pose(ACT_CMP, -5, 7, 9, 131071, -131072, -65536,
                                     -131072, 131071), 1'b1, '{1'b0, 32'd0, 26'd0}));

    foreach (directed[k]) begin
      send_pose(directed[k].pose);
      if (directed[k].has_verdict) begin
        // The hand-typed result must agree with what the predictor queued.
        if (pending_verdicts[$] !== directed[k].verdict) begin
          $error("directed row %0d: typed verdict %0h, predicted %0h", k,
                 directed[k].verdict, pending_verdicts[$]);
          errors++;
        end
      end
    end
    drain();

    trans_set = '{32'd0, 32'hFFFFFFFF, 32'd6554, 32'd200000};
    rot_set   = '{26'd0, 26'd35389440, 26'h3FFFFFF, 26'd327680};

    // Three idling phases of two passes each, with fresh thresholds before
    // every pass.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_TRANS, trans_set[ph % 4]);
      write_reg(CFG_ROT, 32'(rot_set[(ph + 1) % 4]));
      write_reg(CFG_SPARE, $urandom);
      if (ph < 2) begin
        send_idle_pct = 25; recv_idle_pct = 61;
      end else if (ph < 4) begin
        send_idle_pct = 61; recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;  recv_idle_pct = 0;
      end
      for (int n = 0; n < 75; n++) begin
        want_load = ($urandom_range(3) == 0);
        send_pose(rand_pose(want_load ? ACT_LOAD : ACT_CMP));
      end
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard limit far beyond the slowest correct run.
  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/pcd_pkg.sv
src/pcd_if.sv
src/pcd_cordic.sv
src/pcd_isqrt.sv
src/pose_change_detector_top.sv
src/pcd_checker.sv
verif/testbench.sv
